@@ rtl/fec_frame_reassembly_tracker_top_macros.svh @@
// Assertion macros for the frame reassembly tracker.
`ifndef FEC_FRAME_REASSEMBLY_TRACKER_TOP_MACROS_SVH
`define FEC_FRAME_REASSEMBLY_TRACKER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FFRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FFRT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define FFRT_ASSERT(lbl, prop, msg)
`define FFRT_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/ffrt_pkg.sv @@
// Shared constants and types of the frame reassembly tracker.
package ffrt_pkg;
  localparam int unsigned WINDOW    = 16;
  localparam int unsigned SLOT_W    = $clog2(WINDOW);
  localparam int unsigned MAX_FRAGS = 64;
  localparam int unsigned FRAG_W    = 6;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned FRAME_W   = 32;
  localparam int unsigned PAY_W     = 16;
  localparam int unsigned BYTES_W   = 22;
  localparam int unsigned RECV_W    = 8;
  localparam int unsigned MASK_W    = 64;
  localparam int unsigned KIND_W    = 3;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 152;
  localparam int unsigned OUT_TUSER_W = 3;

  localparam logic [KIND_W-1:0] KIND_ACCEPTED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OLD       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OOW       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MALFORMED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DELIVERED = 3'd4;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic               is_key;
    logic               is_repair;
    logic [FRAG_W-1:0]  frag_index;
    logic [CNT_W-1:0]   data_frags;
    logic [CNT_W-1:0]   repair_frags;
    logic [PAY_W-1:0]   payload_bytes;
    logic               hdr_bad;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FRAME_W-1:0] delivered_frame;
    logic [BYTES_W-1:0] frame_bytes;
    logic [FRAME_W-1:0] skipped_frames;
    logic [MASK_W-1:0]  missing_mask;
  } result_t;
endpackage

@@ rtl/ffrt_front.sv @@
// Front end: takes datagram header beats and flags malformed headers.
module ffrt_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ffrt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic [ffrt_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                              item_valid_o,
  input  logic                              item_ready_i,
  output ffrt_pkg::item_t                   item_o
);
  import ffrt_pkg::*;

  logic  valid_q;
  item_t item_q, item_d;
  logic [CNT_W-1:0] grp;

  assign s_axis_tready = !valid_q || item_ready_i;

  always_comb begin
    item_d.frame_number  = s_axis_tdata[31:0];
    item_d.frag_index    = s_axis_tdata[37:32];
    item_d.data_frags    = s_axis_tdata[44:38];
    item_d.repair_frags  = s_axis_tdata[51:45];
    item_d.payload_bytes = s_axis_tdata[67:52];
    item_d.is_key        = s_axis_tuser[0];
    item_d.is_repair     = s_axis_tuser[1];
    grp = item_d.is_repair ? item_d.repair_frags : item_d.data_frags;
    item_d.hdr_bad = (item_d.data_frags == '0) ||
                     (item_d.data_frags > CNT_W'(MAX_FRAGS)) ||
                     (item_d.repair_frags > CNT_W'(MAX_FRAGS)) ||
                     ({1'b0, item_d.frag_index} >= grp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;
endmodule

@@ rtl/ffrt_queue.sv @@
// Two-entry queue of classified headers between front and back end.
module ffrt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  ffrt_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output ffrt_pkg::item_t pop_item_o
);
  import ffrt_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end
endmodule

@@ rtl/ffrt_back.sv @@
// Back end: slot table update, drain scan and result output register.
module ffrt_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              item_valid_i,
  output logic                              item_pop_o,
  input  ffrt_pkg::item_t                   item_i,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ffrt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic [ffrt_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  output logic                              m_axis_tlast
);
  import ffrt_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_PUSH = 3'd4;
  localparam logic [2:0] ST_JUMP = 3'd5;
  localparam logic [2:0] ST_DLV  = 3'd6;

  logic [2:0] state_q, state_d;

  logic [WINDOW-1:0]  slot_valid_q, slot_valid_d;
  logic [FRAME_W-1:0] slot_frame_q [WINDOW];
  logic               slot_key_q   [WINDOW];
  logic [CNT_W-1:0]   slot_dcnt_q  [WINDOW];
  logic [CNT_W-1:0]   slot_rcnt_q  [WINDOW];
  logic [RECV_W-1:0]  slot_recv_q  [WINDOW];
  logic [BYTES_W-1:0] slot_bytes_q [WINDOW];
  logic [MASK_W-1:0]  slot_hd_q    [WINDOW];
  logic [MASK_W-1:0]  slot_hr_q    [WINDOW];

  logic [FRAME_W-1:0] ne_q, ne_d;
  item_t              item_q;
  result_t            pend_q, pend_d;
  logic [SLOT_W-1:0]  sel_q, sel_d, t_q, t_d;
  logic               best_vld_q, best_vld_d;
  logic [FRAME_W-1:0] skip_q, skip_d;
  logic               more_q, more_d, jump_q, jump_d;

  logic               m_valid_q, m_last_q;
  result_t            out_q;

  logic [WINDOW-1:0]  complete;
  logic [SLOT_W-1:0]  us;
  logic               held, bad, dup, upd_wr;
  logic [FRAME_W-1:0] diff;
  logic [MASK_W-1:0]  cur_hd, cur_hr, bit1, new_hd, new_hr;
  logic [RECV_W-1:0]  cur_recv, new_recv;
  logic [BYTES_W-1:0] cur_bytes, new_bytes;
  logic [KIND_W-1:0]  status;
  logic [SLOT_W-1:0]  cs;
  logic               cand, push_ok;
  logic [FRAME_W-1:0] ne_inc;
  logic [MASK_W-1:0]  low_mask;

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      complete[i] = slot_valid_q[i] && (slot_recv_q[i] >= {1'b0, slot_dcnt_q[i]});
    end
  end

  // datagram update
  always_comb begin
    us   = item_q.frame_number[SLOT_W-1:0];
    diff = item_q.frame_number - ne_q;
    held = slot_valid_q[us] && (slot_frame_q[us] == item_q.frame_number);
    bad  = item_q.hdr_bad || (held && ((slot_key_q[us] != item_q.is_key) ||
           (slot_dcnt_q[us] != item_q.data_frags) ||
           (slot_rcnt_q[us] != item_q.repair_frags)));
    if (item_q.frame_number < ne_q)          status = KIND_OLD;
    else if (diff >= FRAME_W'(WINDOW))       status = KIND_OOW;
    else if (bad)                            status = KIND_MALFORMED;
    else                                     status = KIND_ACCEPTED;
    cur_hd    = held ? slot_hd_q[us] : '0;
    cur_hr    = held ? slot_hr_q[us] : '0;
    cur_recv  = held ? slot_recv_q[us] : '0;
    cur_bytes = held ? slot_bytes_q[us] : '0;
    bit1      = MASK_W'(1) << item_q.frag_index;
    dup       = item_q.is_repair ? |(cur_hr & bit1) : |(cur_hd & bit1);
    new_hd    = (item_q.is_repair || dup) ? cur_hd : (cur_hd | bit1);
    new_hr    = (!item_q.is_repair || dup) ? cur_hr : (cur_hr | bit1);
    new_recv  = dup ? cur_recv : cur_recv + RECV_W'(1);
    new_bytes = (dup || item_q.is_repair) ? cur_bytes :
                cur_bytes + BYTES_W'(item_q.payload_bytes);
    upd_wr    = (state_q == ST_UPD) && (status == KIND_ACCEPTED);
  end

  always_comb begin
    cs       = ne_q[SLOT_W-1:0];
    cand     = complete[t_q] && slot_key_q[t_q] && (slot_frame_q[t_q] > ne_q) &&
               (!best_vld_q || (slot_frame_q[t_q] > slot_frame_q[sel_q]));
    push_ok  = !m_valid_q || m_axis_tready;
    ne_inc   = ne_q + FRAME_W'(1);
    low_mask = (slot_dcnt_q[sel_q] == CNT_W'(MASK_W)) ? '1 :
               ((MASK_W'(1) << slot_dcnt_q[sel_q][FRAG_W-1:0]) - MASK_W'(1));
  end

  always_comb begin
    state_d      = state_q;
    slot_valid_d = slot_valid_q;
    ne_d         = ne_q;
    pend_d       = pend_q;
    sel_d        = sel_q;
    t_d          = t_q;
    best_vld_d   = best_vld_q;
    skip_d       = skip_q;
    more_d       = more_q;
    jump_d       = jump_q;
    item_pop_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          state_d    = ST_UPD;
        end
      end
      ST_UPD: begin
        pend_d = '{kind: status, default: '0};
        if (upd_wr) slot_valid_d[us] = 1'b1;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (slot_valid_q[cs] && (slot_frame_q[cs] == ne_q) && complete[cs]) begin
          sel_d   = cs;
          skip_d  = '0;
          more_d  = 1'b1;
          jump_d  = 1'b0;
          state_d = ST_PUSH;
        end else begin
          t_d        = '0;
          best_vld_d = 1'b0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cand) begin
          sel_d      = t_q;
          best_vld_d = 1'b1;
        end
        t_d = t_q + SLOT_W'(1);
        if (t_q == SLOT_W'(WINDOW - 1)) begin
          more_d  = cand || best_vld_q;
          jump_d  = 1'b1;
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push_ok) begin
          if (!more_q)     state_d = ST_IDLE;
          else if (jump_q) state_d = ST_JUMP;
          else             state_d = ST_DLV;
        end
      end
      ST_JUMP: begin
        skip_d = slot_frame_q[sel_q] - ne_q;
        ne_d   = slot_frame_q[sel_q];
        for (int i = 0; i < WINDOW; i++) begin
          if (slot_frame_q[i] < slot_frame_q[sel_q]) slot_valid_d[i] = 1'b0;
        end
        state_d = ST_DLV;
      end
      ST_DLV: begin
        pend_d.kind            = KIND_DELIVERED;
        pend_d.delivered_frame = slot_frame_q[sel_q];
        pend_d.frame_bytes     = slot_bytes_q[sel_q];
        pend_d.skipped_frames  = skip_q;
        pend_d.missing_mask    = ~slot_hd_q[sel_q] & low_mask;
        ne_d = ne_inc;
        for (int i = 0; i < WINDOW; i++) begin
          if (slot_frame_q[i] < ne_inc) slot_valid_d[i] = 1'b0;
        end
        slot_valid_d[sel_q] = 1'b0;
        state_d = ST_CHK;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slot_valid_q <= '0;
      ne_q         <= '0;
      m_valid_q    <= 1'b0;
      more_q       <= 1'b0;
      jump_q       <= 1'b0;
      best_vld_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_valid_q <= slot_valid_d;
      ne_q         <= ne_d;
      more_q       <= more_d;
      jump_q       <= jump_d;
      best_vld_q   <= best_vld_d;
      if (state_q == ST_PUSH && push_ok) m_valid_q <= 1'b1;
      else if (m_axis_tready)            m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    sel_q  <= sel_d;
    t_q    <= t_d;
    skip_q <= skip_d;
    if (item_pop_o) item_q <= item_i;
    if (state_q == ST_PUSH && push_ok) begin
      out_q    <= pend_q;
      m_last_q <= !more_q;
    end
    if (upd_wr) begin
      slot_frame_q[us] <= item_q.frame_number;
      slot_key_q[us]   <= item_q.is_key;
      slot_dcnt_q[us]  <= item_q.data_frags;
      slot_rcnt_q[us]  <= item_q.repair_frags;
      slot_recv_q[us]  <= new_recv;
      slot_bytes_q[us] <= new_bytes;
      slot_hd_q[us]    <= new_hd;
      slot_hr_q[us]    <= new_hr;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {2'b00, out_q.missing_mask, out_q.skipped_frames,
                          out_q.frame_bytes, out_q.delivered_frame};

  `include "fec_frame_reassembly_tracker_top_macros.svh"

  `FFRT_ASSERT(a_ne_moves, $stable(ne_q) || $past(state_q == ST_JUMP || state_q == ST_DLV), "next expected moved")
  `FFRT_ASSERT_IMPL(a_dlv_valid, state_q == ST_DLV, slot_valid_q[sel_q], "delivering an empty slot")
  `FFRT_ASSERT_IMPL(a_pop_idle, item_pop_o, state_q == ST_IDLE && item_valid_i, "pop outside idle")
  `FFRT_ASSERT_IMPL(a_dlv_done, state_q == ST_DLV, pend_d.kind == KIND_DELIVERED && !slot_valid_d[sel_q], "delivery did not retire slot")
endmodule

@@ rtl/fec_frame_reassembly_tracker_top.sv @@
// Top level of the frame reassembly tracker.
// Each input beat is one datagram header; it is classified in the front end, queued, and the
// back end updates a 16-slot frame table and then drains deliverable frames. Every datagram
// gives a status beat followed by zero or more delivery beats; tlast marks the final one. After
// each update and each delivery the back end checks the next expected frame and, if it is not
// complete, scans the slot table for the newest complete key frame, one slot per cycle. An
// in-order delivery passes push and deliver, a skip-ahead one push, jump and deliver.
module fec_frame_reassembly_tracker_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // frame_number, frag_index, data_frags, repair_frags, payload_bytes
  input  logic [ffrt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // is_key, is_repair
  input  logic [ffrt_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // delivered_frame, frame_bytes, skipped_frames, missing_mask
  output logic [ffrt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // kind
  output logic [ffrt_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  output logic                              m_axis_tlast
);
  import ffrt_pkg::*;

  logic  f_valid, f_ready, q_valid, q_pop;
  item_t f_item, q_item;

  ffrt_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .item_valid_o (f_valid), .item_ready_i (f_ready), .item_o (f_item)
  );

  ffrt_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i (f_valid), .push_ready_o (f_ready), .push_item_i (f_item),
    .pop_valid_o (q_valid), .pop_i (q_pop), .pop_item_o (q_item)
  );

  ffrt_back u_back (
    .clk_i, .rst_ni,
    .item_valid_i (q_valid), .item_pop_o (q_pop), .item_i (q_item),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );
endmodule

@@ sim/ffrt_checker.sv @@
// Predicts and checks the tracker's status and delivery beats.
module ffrt_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [ffrt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [ffrt_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [ffrt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [ffrt_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  input  logic                             m_axis_tlast,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o,
  output logic [ffrt_pkg::FRAME_W-1:0]     head_frame_o,
  output int unsigned                      deliveries_o,
  output int unsigned                      skips_o
);
  import ffrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FRAME_W-1:0] frame;
    logic [BYTES_W-1:0] bytes;
    logic [FRAME_W-1:0] skip;
    logic [MASK_W-1:0]  mask;
    logic               last;
  } beat_t;

  beat_t expected_beats[$];

  logic [FRAME_W-1:0] head_frame;
  logic               sl_valid [WINDOW];
  logic [FRAME_W-1:0] sl_frame [WINDOW];
  logic               sl_key   [WINDOW];
  logic [CNT_W-1:0]   sl_dcnt  [WINDOW];
  logic [CNT_W-1:0]   sl_rcnt  [WINDOW];
  logic [RECV_W-1:0]  sl_recv  [WINDOW];
  logic [BYTES_W-1:0] sl_bytes [WINDOW];
  logic [MASK_W-1:0]  sl_have_d[WINDOW];
  logic [MASK_W-1:0]  sl_have_r[WINDOW];

  assign pending_o    = expected_beats.size();
  assign head_frame_o = head_frame;

  function automatic logic complete(int s);
    return sl_valid[s] && (sl_recv[s] >= {1'b0, sl_dcnt[s]});
  endfunction

  task automatic drop_stale();
    for (int s = 0; s < WINDOW; s++)
      if (sl_valid[s] && sl_frame[s] < head_frame) sl_valid[s] = 1'b0;
  endtask

  task automatic hand_over(int s, logic [FRAME_W-1:0] skip, ref beat_t outq[$]);
    beat_t b;
    b = '0;
    b.kind  = KIND_DELIVERED;
    b.frame = sl_frame[s];
    b.bytes = sl_bytes[s];
    b.skip  = skip;
    for (int i = 0; i < sl_dcnt[s] && i < 64; i++)
      if (!sl_have_d[s][i]) b.mask[i] = 1'b1;
    outq.push_back(b);
    deliveries_o++;
    if (skip != 0) skips_o++;
    sl_valid[s] = 1'b0;
    head_frame = head_frame + 1;
    drop_stale();
  endtask

  task automatic track_datagram(logic [IN_TDATA_W-1:0] d, logic [IN_TUSER_W-1:0] u);
    logic [FRAME_W-1:0] f, skip;
    logic               key, rep, held, bad;
    logic [FRAG_W-1:0]  idx;
    logic [CNT_W-1:0]   dcnt, rcnt;
    logic [PAY_W-1:0]   pay;
    int                 s, best;
    beat_t              b;
    beat_t              outq[$];
    f    = d[31:0];
    idx  = d[37:32];
    dcnt = d[44:38];
    rcnt = d[51:45];
    pay  = d[67:52];
    key  = u[0];
    rep  = u[1];
    b    = '0;
    if (f < head_frame) begin
      b.kind = KIND_OLD;
    end else if (f - head_frame >= WINDOW) begin
      b.kind = KIND_OOW;
    end else begin
      s    = f % WINDOW;
      held = sl_valid[s] && sl_frame[s] == f;
      bad  = dcnt == 0 || dcnt > MAX_FRAGS || rcnt > MAX_FRAGS;
      if (held && (sl_key[s] != key || sl_dcnt[s] != dcnt || sl_rcnt[s] != rcnt)) bad = 1;
      if (!bad && {1'b0, idx} >= (rep ? rcnt : dcnt)) bad = 1;
      if (bad) begin
        b.kind = KIND_MALFORMED;
      end else begin
        if (!held) begin
          sl_valid[s]  = 1'b1;
          sl_frame[s]  = f;
          sl_key[s]    = key;
          sl_dcnt[s]   = dcnt;
          sl_rcnt[s]   = rcnt;
          sl_recv[s]   = '0;
          sl_bytes[s]  = '0;
          sl_have_d[s] = '0;
          sl_have_r[s] = '0;
        end
        if (rep ? !sl_have_r[s][idx] : !sl_have_d[s][idx]) begin
          if (rep) sl_have_r[s][idx] = 1'b1;
          else sl_have_d[s][idx] = 1'b1;
          sl_recv[s] = sl_recv[s] + 1;
          if (!rep) sl_bytes[s] = sl_bytes[s] + pay;
        end
        b.kind = KIND_ACCEPTED;
      end
    end
    outq.push_back(b);
    while (outq.size() < 1 + WINDOW) begin
      s = head_frame % WINDOW;
      if (sl_valid[s] && sl_frame[s] == head_frame && complete(s)) begin
        hand_over(s, '0, outq);
        continue;
      end
      best = -1;
      for (int t = 0; t < WINDOW; t++)
        if (complete(t) && sl_key[t] && sl_frame[t] > head_frame &&
            (best < 0 || sl_frame[t] > sl_frame[best])) best = t;
      if (best < 0) break;
      skip = sl_frame[best] - head_frame;
      head_frame = sl_frame[best];
      drop_stale();
      hand_over(best, skip, outq);
    end
    outq[outq.size()-1].last = 1'b1;
    foreach (outq[i]) expected_beats.push_back(outq[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t e, a;
    if (!rst_ni) begin
      head_frame = '0;
      for (int s = 0; s < WINDOW; s++) sl_valid[s] = 1'b0;
      expected_beats.delete();
      fail_count_o = 0;
      deliveries_o = 0;
      skips_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        a.kind  = m_axis_tuser;
        a.frame = m_axis_tdata[31:0];
        a.bytes = m_axis_tdata[53:32];
        a.skip  = m_axis_tdata[85:54];
        a.mask  = m_axis_tdata[149:86];
        a.last  = m_axis_tlast;
        if (expected_beats.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected beat: %p", a);
        end else begin
          e = expected_beats[0];
          expected_beats.delete(0);
          if (a !== e) begin
            fail_count_o++;
            if (fail_count_o <= 10) $display("mismatch: expected %p actual %p", e, a);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) track_datagram(s_axis_tdata, s_axis_tuser);
    end
  end
endmodule

@@ sim/tb_fec_frame_reassembly_tracker_top.sv @@
// Stimulus and verdict for the frame reassembly tracker.
module tb_fec_frame_reassembly_tracker_top;
  import ffrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;
  int unsigned            fail_count, pending, deliveries, skips;
  logic [FRAME_W-1:0]     head_frame;
  logic                   calm = 1'b0;
  int unsigned            sent = 0;

  logic                   f_key [logic [31:0]];
  logic [CNT_W-1:0]       f_dcnt[logic [31:0]];
  logic [CNT_W-1:0]       f_rcnt[logic [31:0]];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  fec_frame_reassembly_tracker_top dut (.*);

  ffrt_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending), .head_frame_o(head_frame),
    .deliveries_o(deliveries), .skips_o(skips)
  );

  always @(posedge clk_i) m_axis_tready <= calm || ($urandom_range(99) >= 9);

  task automatic send(logic [31:0] f, logic key, logic rep, logic [5:0] idx,
                      logic [6:0] dcnt, logic [6:0] rcnt, logic [15:0] pay);
    while (!calm && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, pay, rcnt, dcnt, idx, f};
    s_axis_tuser  <= {rep, key};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  // one frame: shuffled fragments, sometimes short, sometimes with repeats
  task automatic send_frame(logic [31:0] f);
    int          ids[$];
    int          n, k;
    if (!f_key.exists(f)) begin
      f_key[f]  = $urandom_range(2) == 0;
      f_dcnt[f] = ($urandom_range(19) == 0) ? 7'd64 : 7'($urandom_range(1, 6));
      f_rcnt[f] = ($urandom_range(19) == 0) ? 7'd64 : 7'($urandom_range(0, 3));
    end
    for (int i = 0; i < f_dcnt[f]; i++) ids.push_back(i);
    for (int i = 0; i < f_rcnt[f]; i++) ids.push_back(64 + i);
    ids.shuffle();
    n = f_dcnt[f] + $urandom_range(1);
    if ($urandom_range(3) == 0) n = $urandom_range(1, f_dcnt[f]);
    if (n > ids.size()) n = ids.size();
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(9) == 0) ? ids[$urandom_range(i)] : ids[i];
      send(f, f_key[f], k >= 64, 6'(k % 64), f_dcnt[f], f_rcnt[f], 16'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    calm = 1'b1;
    // directed
    send(0, 1, 0, 0, 1, 0, 16'hFFFF);              // complete at once
    send(0, 1, 0, 0, 1, 0, 16'h1234);              // old frame
    send(32'hFFFF_FFFF, 1, 1, 63, 64, 64, 16'hFFFF); // out of window
    send(32'h8000_0010, 0, 0, 0, 1, 0, 0);         // out of window
    send(1, 0, 0, 0, 0, 0, 5);                     // zero data count
    send(1, 0, 0, 0, 65, 0, 5);                    // data count too big
    send(1, 0, 0, 0, 2, 65, 5);                    // repair count too big
    send(1, 0, 0, 2, 2, 1, 5);                     // data index too big
    send(1, 0, 1, 0, 2, 0, 5);                     // repair with no repair group
    send(1, 0, 0, 0, 2, 1, 100);                   // claims slot
    send(1, 1, 0, 1, 2, 1, 7);                     // key mismatch
    send(1, 0, 0, 1, 3, 1, 7);                     // count mismatch
    send(1, 0, 0, 0, 2, 1, 100);                   // duplicate
    send(3, 0, 0, 0, 1, 0, 9);                     // waits behind frame 1
    send(5, 1, 0, 63, 64, 64, 16'hFFFF);           // big key frame
    for (int i = 0; i < 62; i++) if (i % 9 != 0) send(5, 1, 0, 6'(i), 64, 64, 16'hFFFF);
    for (int i = 0; i < 8; i++) send(5, 1, 1, 6'(63 - i), 64, 64, 16'hAAAA); // repaired
    send(15, 1, 0, 0, 1, 0, 1);                    // complete key frame, skip ahead to it
    send(22, 0, 0, 0, 1, 0, 1);                    // in window, waits behind frame 16
    calm = 1'b0;
    // random
    while (sent < 400) begin
      if (sent > 250 && sent < 330) calm = 1'b1;
      else calm = 1'b0;
      case ($urandom_range(9))
        0: send(head_frame + $urandom_range(20), 1'($urandom), 1'($urandom), 6'($urandom),
                7'($urandom), 7'($urandom), 16'($urandom));
        1: send(($urandom_range(1) ? $urandom : head_frame - $urandom_range(1, 4)),
                1'($urandom), 1'($urandom), 6'($urandom), 7'($urandom_range(1, 64)),
                7'($urandom_range(64)), 16'($urandom));
        default: send_frame(head_frame + (($urandom_range(4) == 0) ?
                                          $urandom_range(15) : $urandom_range(3)));
      endcase
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("Sent %0d datagram headers; %0d frames delivered, %0d after a key-frame skip.",
             sent, deliveries, skips);
    if (fail_count == 0 && pending == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out waiting for tracker output");
    $display("Verification failed");
    $finish;
  end
endmodule

@@ fec_frame_reassembly_tracker_top.f @@
+incdir+rtl
rtl/ffrt_pkg.sv
rtl/ffrt_front.sv
rtl/ffrt_queue.sv
rtl/ffrt_back.sv
rtl/fec_frame_reassembly_tracker_top.sv
sim/ffrt_checker.sv
sim/tb_fec_frame_reassembly_tracker_top.sv
